// ===== rtl/rarg_pkg.sv =====
// shared types and constants for the range arg-max tree core
// no dependencies; used by rarg_engine and range_argmax_tree_with_delete_core
package rarg_pkg;

  localparam int unsigned SIZE    = 1024;
  localparam int unsigned LEAVES  = SIZE;
  localparam int unsigned LEAF_AW = $clog2(LEAVES);
  localparam int unsigned NODE_AW = LEAF_AW + 1;

  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 16;

  localparam logic [POS_W-1:0] ENTRIES_RESET = POS_W'(1024);

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // word index of the only register
  localparam logic REG_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] found_index;
    logic [VAL_W-1:0] found_value;
    logic             hit;
  } res_t;

endpackage

// ===== rtl/rarg_engine.sv =====
// tournament tree engine: node memory, clearing pass, update walk and range query walk
// depends on rarg_pkg
module rarg_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  rarg_pkg::req_t             req_i,
  input  logic [rarg_pkg::POS_W-1:0] covered_i,
  output logic                       ready_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output rarg_pkg::res_t             res_o
);
  import rarg_pkg::*;

  // node key: dead entries are all zero, live ones compare by value then position
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } key_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_DONE
  } state_e;

  function automatic key_t key_max(key_t a, key_t b);
    return (a > b) ? a : b;
  endfunction

  key_t node_mem [2**NODE_AW];

  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  key_t               mem_wdata;
  logic [NODE_AW-1:0] rd_a_addr;
  logic [NODE_AW-1:0] rd_b_addr;
  key_t               rd_a_q;
  key_t               rd_b_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= node_mem[rd_a_addr];
    rd_b_q <= node_mem[rd_b_addr];
  end

  state_e             state_q, state_d;
  logic [NODE_AW-1:0] idx_q, idx_d;
  key_t               cur_q, cur_d;
  logic [NODE_AW:0]   lo_q, lo_d;
  logic [NODE_AW:0]   hi_q, hi_d;
  logic               va_q, va_d;
  logic               vb_q, vb_d;
  res_t               res_q, res_d;

  logic               pos_ok;
  logic [POS_W-1:0]   pos_m1;
  logic [NODE_AW-1:0] leaf_idx;
  key_t               leaf_key;
  logic [POS_W-1:0]   q_lo;
  logic [POS_W-1:0]   q_hi;
  logic [NODE_AW:0]   l_start;
  logic [NODE_AW:0]   r_start;
  logic [NODE_AW-1:0] parent;
  key_t               upd_key;
  key_t               merge_a;
  key_t               merged;
  logic [NODE_AW:0]   lo_inc;
  logic [NODE_AW:0]   hi_m1;

  assign pos_ok   = (req_i.position != '0) && (req_i.position <= covered_i);
  assign pos_m1   = req_i.position - POS_W'(1);
  assign leaf_idx = {1'b1, pos_m1[LEAF_AW-1:0]};
  assign leaf_key = (req_i.action == ACT_LOAD) ?
                    key_t'{value: req_i.value, pos: req_i.position} : key_t'('0);

  assign q_lo    = (req_i.range_low == '0) ? POS_W'(1) : req_i.range_low;
  assign q_hi    = (req_i.range_high > covered_i) ? covered_i : req_i.range_high;
  // half-open node interval [l, r) over the leaf row
  assign l_start = (NODE_AW+1)'(q_lo) + (NODE_AW+1)'(LEAVES - 1);
  assign r_start = (NODE_AW+1)'(q_hi) + (NODE_AW+1)'(LEAVES);

  assign parent  = idx_q >> 1;
  assign upd_key = key_max(cur_q, rd_a_q);

  assign merge_a = key_max(cur_q, va_q ? rd_a_q : key_t'('0));
  assign merged  = key_max(merge_a, vb_q ? rd_b_q : key_t'('0));
  assign lo_inc  = lo_q + (NODE_AW+1)'(lo_q[0]);
  assign hi_m1   = hi_q - (NODE_AW+1)'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    va_d      = 1'b0;
    vb_d      = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    rd_a_addr = idx_q ^ NODE_AW'(1);
    rd_b_addr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + NODE_AW'(1);
        if (&idx_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          res_d = '0;
          unique case (req_i.action)
            ACT_LOAD, ACT_DELETE: begin
              if (pos_ok) begin
                mem_we    = 1'b1;
                mem_waddr = leaf_idx;
                mem_wdata = leaf_key;
                rd_a_addr = leaf_idx ^ NODE_AW'(1);
                idx_d     = leaf_idx;
                cur_d     = leaf_key;
                state_d   = ST_UPD;
              end else begin
                state_d = ST_DONE;
              end
            end
            ACT_QUERY: begin
              if (q_lo > q_hi) begin
                state_d = ST_DONE;
              end else begin
                lo_d    = l_start;
                hi_d    = r_start;
                cur_d   = '0;
                state_d = ST_QRY;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_UPD: begin
        // sibling arrives now; write the parent and fetch the next sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = upd_key;
        rd_a_addr = parent ^ NODE_AW'(1);
        if (parent == NODE_AW'(1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d = parent;
          cur_d = upd_key;
        end
      end
      ST_QRY: begin
        cur_d = merged;
        if (lo_q < hi_q) begin
          rd_a_addr = lo_q[NODE_AW-1:0];
          rd_b_addr = hi_m1[NODE_AW-1:0];
          va_d      = lo_q[0];
          vb_d      = hi_q[0];
          lo_d      = lo_inc >> 1;
          hi_d      = hi_q >> 1;
        end else begin
          res_d.found_index = merged.pos;
          res_d.found_value = merged.value;
          res_d.hit         = (merged.pos != '0);
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      cur_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      va_q    <= va_d;
      vb_q    <= vb_d;
      res_q   <= res_d;
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) |-> !mem_we)
    else $error("node memory written during a query walk");

  a_upd_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (mem_waddr != rd_a_addr))
    else $error("update walk reads the entry it writes");

  a_upd_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (idx_q > NODE_AW'(1)))
    else $error("update walk went past the root");

  a_hit_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.hit == (res_o.found_index != '0)))
    else $error("hit flag disagrees with found index");

  a_query_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) |-> (hi_q <= (NODE_AW+1)'(2 * LEAVES)))
    else $error("query interval beyond the node array");

endmodule

// ===== rtl/range_argmax_tree_with_delete_core.sv =====
// A load or delete writes the leaf, then does one node-memory read-modify-write per tree level
// above it (10 levels) before the result passes to the output register. A query reads two nodes
// per level (up to 11 levels), then merges the last pair, then hands off. Ignored items and empty
// ranges go straight to the hand-off.
// One item is in flight at a time; the next beat is accepted the cycle after the result is
// registered.
// Reset: asynchronous, active low; afterwards a clearing pass over all 2048 node entries empties
// the node memory, with s_axis_tready low meanwhile (register writes are taken as ever).
module range_argmax_tree_with_delete_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // position[10:0], value[26:11], range_low[37:27], range_high[48:38], zero fill
  input  logic [rarg_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  logic [rarg_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_index[10:0], found_value[26:11], zero fill
  output logic [rarg_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // hit[0]
  output logic                           m_axis_tuser,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rarg_pkg::APB_AW-1:0]    paddr,
  input  logic [rarg_pkg::APB_DW-1:0]    pwdata,
  output logic [rarg_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import rarg_pkg::*;

  logic [POS_W-1:0] entries_q;
  logic [POS_W-1:0] covered;
  logic             cfg_wr;

  req_t req;
  res_t eng_res;
  logic eng_ready;
  logic eng_res_valid;
  logic res_take;

  logic m_valid_q;
  res_t m_res_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_ENTRIES);
  assign prdata = (paddr[2] == REG_ENTRIES) ? APB_DW'(entries_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
    end else if (cfg_wr) begin
      entries_q <= pwdata[POS_W-1:0];
    end
  end

  // out-of-range counts act as the nearest legal one
  always_comb begin
    if (entries_q == '0) begin
      covered = POS_W'(1);
    end else if (entries_q > POS_W'(SIZE)) begin
      covered = POS_W'(SIZE);
    end else begin
      covered = entries_q;
    end
  end

  assign req.action     = action_e'(s_axis_tuser);
  assign req.position   = s_axis_tdata[POS_W-1:0];
  assign req.value      = s_axis_tdata[POS_W+VAL_W-1:POS_W];
  assign req.range_low  = s_axis_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];
  assign req.range_high = s_axis_tdata[3*POS_W+VAL_W-1:2*POS_W+VAL_W];

  assign s_axis_tready = eng_ready;

  rarg_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid & eng_ready),
    .req_i       (req),
    .covered_i   (covered),
    .ready_o     (eng_ready),
    .res_valid_o (eng_res_valid),
    .res_ready_i (res_take),
    .res_o       (eng_res)
  );

  // output register frees the engine while a beat waits downstream
  assign res_take = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_res_q   <= '0;
    end else if (eng_res_valid && res_take) begin
      m_valid_q <= 1'b1;
      m_res_q   <= eng_res;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({m_res_q.found_value, m_res_q.found_index});
  assign m_axis_tuser  = m_res_q.hit;

endmodule
